/* rtl/clrr_pkg.sv */
`default_nettype none

package clrr_pkg;

  localparam int unsigned RAW_W = 16;

  localparam logic [31:0] LONG_TAPS   = 32'hB4BC_D35C;
  localparam logic [30:0] SHORT_TAPS  = 31'h7A5B_C2E3;
  localparam logic [31:0] SEED_OFFSET = 32'h2F2F_2F2F;
  localparam logic [31:0] LONG_MOD    = 32'hFFFF_FFFF;
  localparam logic [31:0] SHORT_MOD   = 32'h7FFF_FFFF;

  localparam logic ADDR_SEED = 1'b0;

  function automatic logic [31:0] long_step(input logic [31:0] r);
    logic [31:0] s;
    s = r >> 1;
    if (r[0]) begin
      s = s ^ LONG_TAPS;
    end
    return s;
  endfunction

  function automatic logic [30:0] short_step(input logic [30:0] r);
    logic [30:0] s;
    s = r >> 1;
    if (r[0]) begin
      s = s ^ SHORT_TAPS;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/clrr_lfsr.sv */
`default_nettype none

module clrr_lfsr
  import clrr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire logic [31:0]      seed,
  input  wire logic             step,
  output logic      [RAW_W-1:0] raw
);

  logic [31:0] long_reg;
  logic [30:0] short_reg;
  logic [31:0] long_seed;
  logic [30:0] short_seed;
  logic [31:0] offset_sum;
  logic [31:0] folded;

  always_comb begin
    long_seed  = (seed == LONG_MOD) ? 32'd0 : seed;
    offset_sum = seed + SEED_OFFSET;
    folded     = {1'b0, offset_sum[30:0]} + {31'd0, offset_sum[31]};
    if (folded >= SHORT_MOD) begin
      folded = folded - SHORT_MOD;
    end
    short_seed = folded[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_reg  <= 32'd0;
      short_reg <= SEED_OFFSET[30:0];
    end else if (load) begin
      long_reg  <= long_seed;
      short_reg <= short_seed;
    end else if (step) begin
      long_reg  <= long_step(long_step(long_reg));
      short_reg <= short_step(short_reg);
    end
  end

  assign raw = long_reg[RAW_W-1:0] ^ short_reg[RAW_W-1:0];

endmodule

`default_nettype wire

/* rtl/clrr_serial_mod.sv */
`default_nettype none

module clrr_serial_mod
  import clrr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [RAW_W-1:0] dividend,
  input  wire logic [31:0]      divisor,
  output logic                  done,
  output logic      [RAW_W-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(RAW_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [RAW_W-1:0] dvd;
  logic [31:0]      dvs;
  logic [RAW_W-1:0] shifted;
  logic [RAW_W-1:0] remainder_next;

  // The partial remainder never exceeds the dividend prefix, so it stays within RAW_W bits.
  always_comb begin
    shifted = {remainder[RAW_W-2:0], dvd[RAW_W-1]};
    if ({{(32-RAW_W){1'b0}}, shifted} >= dvs) begin
      remainder_next = shifted - dvs[RAW_W-1:0];
    end else begin
      remainder_next = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(RAW_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= dvd << 1;
      remainder <= remainder_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/combined_lfsr_random_range.sv */
// Raw requests and range requests with a bad range pass through ST_PREP and ST_WRITE before
// out_valid rises; valid range requests also wait in ST_DIV for the bit-serial
// remainder unit that retires one dividend bit per cycle over 16 bits.
// One request is in flight at a time; the next input beat is taken the cycle after the
// result is loaded, and ST_WRITE holds the result while the output is stalled.
// Reset is synchronous and leaves the block idle with the seed at 0 and both LFSRs loaded from it.
`default_nettype none

module combined_lfsr_random_range
  import clrr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [31:0] range_min,
  input  wire logic [31:0] range_max,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] value,
  output logic             bad_range
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_WRITE
  } state_t;

  state_t           state;
  logic [31:0]      seed;
  logic             seed_write;
  logic             in_beat;
  logic             cmd_q;
  logic [31:0]      min_q;
  logic [31:0]      max_q;
  logic [31:0]      result;
  logic             result_bad;
  logic [RAW_W-1:0] raw;
  logic [RAW_W-1:0] rem;
  logic             div_start;
  logic             div_done;
  logic             range_ok;
  logic [31:0]      span;

  assign pready     = 1'b1;
  assign prdata     = seed;
  assign seed_write = psel && penable && pwrite && pready && (paddr[2] == ADDR_SEED);
  assign in_ready   = (state == ST_IDLE);
  assign in_beat    = in_valid && in_ready;
  assign range_ok   = $signed(min_q) < $signed(max_q);
  assign span       = max_q - min_q;
  assign div_start  = (state == ST_PREP) && cmd_q && range_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd0;
    end else if (seed_write) begin
      seed <= pwdata;
    end
  end

  clrr_lfsr u_lfsr (
    .clk  (clk),
    .rst  (rst),
    .load (seed_write),
    .seed (pwdata),
    .step (in_beat),
    .raw  (raw)
  );

  clrr_serial_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (raw),
    .divisor   (span),
    .done      (div_done),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_q <= command;
      min_q <= range_min;
      max_q <= range_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_WRITE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (!cmd_q) begin
            result     <= {{(32-RAW_W){1'b0}}, raw};
            result_bad <= 1'b0;
            state      <= ST_WRITE;
          end else if (!range_ok) begin
            result     <= 32'd0;
            result_bad <= 1'b1;
            state      <= ST_WRITE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            result     <= {{(32-RAW_W){1'b0}}, rem} + min_q;
            result_bad <= 1'b0;
            state      <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (!out_valid || out_ready) begin
            value     <= result;
            bad_range <= result_bad;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import clrr_pkg::*;

  localparam logic CMD_RAW = 1'b0;
  localparam logic CMD_RANGE = 1'b1;
  localparam logic [2:0] SEED_ADDR = {ADDR_SEED, 2'b00};
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] value;
    logic        bad_range;
  } draw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [31:0] range_min = '0;
  logic [31:0] range_max = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value;
  logic        bad_range;

  logic [31:0] long_sr;
  logic [30:0] short_sr;
  draw_t       pending_draws[$];
  draw_t       head_draw;
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          send_gaps = 1'b1;
  bit          recv_stalls = 1'b1;

  always #2 clk = ~clk;

  combined_lfsr_random_range dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .range_min(range_min),
    .range_max(range_max),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value(value),
    .bad_range(bad_range)
  );

  function automatic void reload_generators(input logic [31:0] s);
    logic [31:0] offset_seed;
    offset_seed = s + SEED_OFFSET;
    long_sr = s % LONG_MOD;
    short_sr = 31'(offset_seed % SHORT_MOD);
  endfunction

  function automatic draw_t draw_next(input logic cmd, input logic [31:0] lo,
                                      input logic [31:0] hi);
    draw_t       d;
    logic [31:0] mixed;
    logic [31:0] span;
    for (int k = 0; k < 2; k++) begin
      long_sr = {1'b0, long_sr[31:1]} ^ (long_sr[0] ? LONG_TAPS : 32'h0);
    end
    short_sr = {1'b0, short_sr[30:1]} ^ (short_sr[0] ? SHORT_TAPS : 31'h0);
    mixed = {16'h0, long_sr[15:0] ^ short_sr[15:0]};
    d.value = mixed;
    d.bad_range = 1'b0;
    if (cmd == CMD_RANGE) begin
      if ($signed(lo) < $signed(hi)) begin
        span = hi - lo;
        d.value = (mixed % span) + lo;
      end else begin
        d.value = '0;
        d.bad_range = 1'b1;
      end
    end
    return d;
  endfunction

  always @(posedge clk) begin
    out_ready <= !recv_stalls || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result: value %h bad_range %b", $time, value, bad_range);
        errors++;
      end else begin
        head_draw = pending_draws.pop_front();
        if (value !== head_draw.value) begin
          $display("%0t: value mismatch: expected %h, actual %h", $time, head_draw.value,
                   value);
          errors++;
        end
        if (bad_range !== head_draw.bad_range) begin
          $display("%0t: bad_range mismatch: expected %b, actual %b", $time,
                   head_draw.bad_range, bad_range);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("combined_lfsr_random_range test failed");
      $finish;
    end
  end

  task automatic send_request(input logic cmd, input logic [31:0] lo, input logic [31:0] hi);
    int gap;
    if (send_gaps && $urandom_range(99) < 26) begin
      gap = ($urandom_range(99) < 15) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      command <= 1'($urandom);
      range_min <= $urandom;
      range_max <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    range_min <= lo;
    range_max <= hi;
    do @(posedge clk); while (!in_ready);
    pending_draws.push_back(draw_next(cmd, lo, hi));
  endtask

  task automatic send_random_request();
    logic [31:0] lo;
    logic [31:0] hi;
    logic        cmd;
    int          kind;
    kind = $urandom_range(9);
    lo = $urandom;
    hi = $urandom;
    cmd = CMD_RANGE;
    case (kind)
      0, 1, 2: cmd = CMD_RAW;
      3, 4, 5: hi = lo + $urandom_range(1, 40);
      6: hi = lo + $urandom_range(65000, 66000);
      7: ;
      8: hi = lo - $urandom_range(0, 3);
      default: begin
        lo = $urandom_range(200) - 100;
        hi = lo + $urandom_range(1, 1 << 20);
      end
    endcase
    send_request(cmd, lo, hi);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] s);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SEED_ADDR;
    pwdata <= s;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reload_generators(s);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== s) begin
      $display("%0t: seed readback mismatch: expected %h, actual %h", $time, s, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_seed();
    send_request(CMD_RAW, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_RAW, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(CMD_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_RANGE, 32'h0000_0000, 32'h0000_0001);
    send_request(CMD_RANGE, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
    send_request(CMD_RANGE, 32'h8000_0000, 32'h8000_0001);
    send_request(CMD_RANGE, 32'h0000_0005, 32'h0000_0005);
    send_request(CMD_RANGE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_RANGE, 32'hFFFF_FFFB, 32'h0000_0005);
    send_request(CMD_RANGE, 32'h0000_0000, 32'h0001_0000);
    send_request(CMD_RANGE, 32'h0000_0000, 32'h0000_FFFF);
    send_request(CMD_RANGE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CMD_RANGE, 32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_seed_extremes();
    write_seed(32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) begin
      send_request((i % 2 == 0) ? CMD_RAW : CMD_RANGE, 32'hFFFF_FF9C, 32'h0000_0064);
    end
    write_seed(32'h50D0_D0D0);
    for (int i = 0; i < 3; i++) begin
      send_request((i % 2 == 0) ? CMD_RANGE : CMD_RAW, 32'h0000_0003, 32'h0000_0010);
    end
    write_seed(32'h0000_0000);
    for (int i = 0; i < 3; i++) begin
      send_request((i % 2 == 0) ? CMD_RAW : CMD_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
    end
  endtask

  task automatic test_random_seeds();
    for (int phase = 0; phase < 4; phase++) begin
      write_seed($urandom);
      for (int n = 0; n < 250; n++) begin
        if (n == 125) begin
          drain_results();
        end
        send_random_request();
      end
    end
  endtask

  task automatic test_no_idle();
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    write_seed($urandom);
    for (int n = 0; n < 350; n++) begin
      send_random_request();
    end
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
  endtask

  initial begin
    reload_generators(32'h0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_seed();
    test_seed_extremes();
    test_random_seeds();
    test_no_idle();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("combined_lfsr_random_range test passed");
    end else begin
      $display("combined_lfsr_random_range test failed");
    end
    $finish;
  end

endmodule
